FILE: design/bfa_pkg.sv
// Package: shared constants, codes and types of the bitmap frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int FRAME_W    = 13;
  localparam int WIDX_W     = 6;
  localparam int BIT_W      = 6;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_RESERVE = 3'd2,
    OP_CHECK   = 3'd3,
    OP_INIT    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_UNINIT    = 3'd1,
    STS_INVALID   = 3'd2,
    STS_NO_MEM    = 3'd3,
    STS_NOT_FOUND = 3'd4,
    STS_BAD_STATE = 3'd5
  } status_e;

  localparam logic [1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [1:0] CFG_FRAME_SHIFT = 2'd1;
  localparam logic [1:0] CFG_FRAME_COUNT = 2'd2;

  typedef enum logic [1:0] {
    RM_TEST_USED = 2'd0,
    RM_TEST_ANY  = 2'd1,
    RM_SET       = 2'd2,
    RM_CLR       = 2'd3
  } rmode_e;

  typedef struct packed {
    logic [WIDX_W-1:0]    rd_word;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_word;
    logic [WORD_BITS-1:0] wr_data;
  } map_cmd_t;

endpackage
`default_nettype wire

FILE: design/bfa_if.sv
// Interfaces: request, response and configuration channels of the allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [63:0] size_bytes;
  logic [63:0] address;
  logic [63:0] end_address;
  logic        want_used;
  modport source (output valid, opcode, size_bytes, address, end_address, want_used,
                  input ready);
  modport sink (input valid, opcode, size_bytes, address, end_address, want_used,
                output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] alloc_address;
  logic        answer;
  logic [12:0] free_frames;
  modport source (output valid, status, alloc_address, answer, free_frames, input ready);
  modport sink (input valid, status, alloc_address, answer, free_frames, output ready);
endinterface

interface bfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/bfa_map_ram.sv
// Frame bitmap memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bfa_map_ram import bfa_pkg::*; (
  input  logic                 clk_i,
  input  map_cmd_t             cmd_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_word] <= cmd_i.wr_data;
    end
    rdata_q <= mem[cmd_i.rd_word];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/bitmap_frame_allocator.sv
// Top level: bitmap physical frame allocator with next-fit search.
// Items are taken one at a time. Init sweeps the 64-word bitmap at one word per cycle.
// Free, reserve and check pass the address checks in S_PRE1 to S_PRE4 and then read and
// write or test each bitmap word touched in S_RRD and S_RWR (free walks its range twice).
// Alloc scans the map one frame per cycle in S_SSCAN, with a read in S_SRD before each
// word, then marks the words of the run found through S_RRD and S_RWR. The scan is
// bit-serial over the single bitmap read port. A finished word may wait on the response
// channel while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfa_req_if.sink    req_i,
  bfa_rsp_if.source  rsp_o,
  bfa_cfg_if.sink    cfg_i
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PRE1  = 10'b0000000010,
    S_PRE2  = 10'b0000000100,
    S_PRE3  = 10'b0000001000,
    S_PRE4  = 10'b0000010000,
    S_INIT  = 10'b0000100000,
    S_SRD   = 10'b0001000000,
    S_SSCAN = 10'b0010000000,
    S_RRD   = 10'b0100000000,
    S_RWR   = 10'b1000000000
  } state_e;

  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  state_e state_q;
  logic   done_q;

  logic [63:0] cfg_base_q;
  logic [4:0]  cfg_shift_q;
  logic [12:0] cfg_count_q;

  logic [63:0] base_q;
  logic [4:0]  shift_q;
  logic [12:0] count_q;
  logic [6:0]  words_q;
  logic [12:0] free_q;
  logic [5:0]  sw_q;
  logic        init_q;

  logic [2:0]  op_q;
  logic [63:0] size_q, addr_q, eaddr_q;
  logic        want_q;

  logic [63:0] need_q, s_q, eraw_q, off_q, span_q, e_q, sb_q, rem_q, eb_q;
  logic [2:0]  sts_q;
  logic [63:0] aaddr_q;
  logic        hit_q;

  logic [12:0] cur_q, rend_q, rfirst_q, n_q;
  rmode_e      rmode_q;
  logic [5:0]  w_q;

  logic [12:0] f_q, hi_q, run_q, rstart_q;
  logic        pass_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [63:0] out_aaddr_q;
  logic        out_answer_q;
  logic [12:0] out_free_q;

  map_cmd_t             cmd;
  logic [WORD_BITS-1:0] rdata;

  bfa_map_ram u_map_ram (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .rdata_o (rdata)
  );

  logic [63:0] fm, need_c, span_c, eb_c, sbs, ebs, offs;
  logic [12:0] first_c, last_c, nrc;
  logic [12:0] wbase, rrem, ncur;
  logic [6:0]  hi7;
  logic [WORD_BITS-1:0] rmask;
  logic        rlast, fbit, bad_c;
  logic [12:0] f_nx, rs_c;
  logic [6:0]  cnt_words;
  logic [5:0]  tail_c;
  logic [WORD_BITS-1:0] tail_mask;

  assign fm     = ~(ONES << shift_q);
  assign need_c = (size_q >> shift_q) + {63'd0, |(size_q & fm)};
  assign span_c = {51'd0, count_q} << shift_q;
  assign eb_c   = e_q - base_q;
  assign sbs    = sb_q >> shift_q;
  assign ebs    = eb_q >> shift_q;
  assign offs   = off_q >> shift_q;
  assign first_c = (op_q == OP_FREE) ? offs[12:0] : sbs[12:0];
  assign last_c  = ebs[12:0];
  assign nrc     = (last_c > first_c) ? last_c - first_c : 13'd0;

  assign wbase = {cur_q[12:6], 6'd0};
  assign rrem  = rend_q - wbase;
  assign hi7   = (rrem >= 13'd64) ? 7'd64 : rrem[6:0];
  assign rmask = (ONES >> cur_q[5:0]) & ~((hi7 == 7'd64) ? '0 : (ONES >> hi7[5:0]));
  assign ncur  = wbase + {6'd0, hi7};
  assign rlast = (ncur >= rend_q);

  assign fbit = rdata[~f_q[5:0]];
  assign f_nx = f_q + 13'd1;
  assign rs_c = (run_q == 13'd0) ? f_q : rstart_q;

  assign cnt_words = 7'((14'(cfg_count_q) + 14'd63) >> 6);
  assign tail_c    = count_q[5:0];
  assign tail_mask = (tail_c == 6'd0) ? '0 : (ONES >> tail_c);

  always_comb begin
    bad_c = 1'b0;
    unique case (op_q)
      OP_ALLOC: bad_c = (size_q == 64'd0);
      OP_FREE: bad_c = (size_q == 64'd0) || (need_q > {51'd0, count_q}) ||
                       ((addr_q & fm) != 64'd0) || (addr_q < base_q) || (off_q >= span_q);
      OP_RESERVE: bad_c = (size_q == 64'd0) || (e_q < s_q) || (s_q < base_q) ||
                          (e_q < base_q) || (eb_c > span_q);
      OP_CHECK: bad_c = (s_q >= e_q) || (s_q < base_q) || (e_q < base_q) ||
                        (eb_c > span_q);
      default: bad_c = 1'b1;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_word = (state_q == S_SRD || state_q == S_SSCAN) ? f_q[11:6] : cur_q[11:6];
    if (state_q == S_INIT) begin
      cmd.wr_en   = 1'b1;
      cmd.wr_word = w_q;
      cmd.wr_data = ({1'b0, w_q} == words_q - 7'd1) ? tail_mask : '0;
    end else if (state_q == S_RWR && (rmode_q == RM_SET || rmode_q == RM_CLR)) begin
      cmd.wr_en   = 1'b1;
      cmd.wr_word = cur_q[11:6];
      cmd.wr_data = (rmode_q == RM_SET) ? (rdata | rmask) : (rdata & ~rmask);
    end
  end

  assign req_i.ready = (state_q == S_IDLE) && !done_q;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.alloc_address = out_aaddr_q;
  assign rsp_o.answer        = out_answer_q;
  assign rsp_o.free_frames   = out_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      cfg_base_q   <= 64'd0;
      cfg_shift_q  <= 5'd12;
      cfg_count_q  <= 13'd4096;
      base_q       <= 64'd0;
      shift_q      <= 5'd0;
      count_q      <= 13'd0;
      words_q      <= 7'd0;
      free_q       <= 13'd0;
      sw_q         <= 6'd0;
      init_q       <= 1'b0;
      op_q         <= OP_ALLOC;
      size_q       <= 64'd0;
      addr_q       <= 64'd0;
      eaddr_q      <= 64'd0;
      want_q       <= 1'b0;
      need_q       <= 64'd0;
      s_q          <= 64'd0;
      eraw_q       <= 64'd0;
      off_q        <= 64'd0;
      span_q       <= 64'd0;
      e_q          <= 64'd0;
      sb_q         <= 64'd0;
      rem_q        <= 64'd0;
      eb_q         <= 64'd0;
      sts_q        <= STS_OK;
      aaddr_q      <= 64'd0;
      hit_q        <= 1'b0;
      cur_q        <= 13'd0;
      rend_q       <= 13'd0;
      rfirst_q     <= 13'd0;
      n_q          <= 13'd0;
      rmode_q      <= RM_TEST_ANY;
      w_q          <= 6'd0;
      f_q          <= 13'd0;
      hi_q         <= 13'd0;
      run_q        <= 13'd0;
      rstart_q     <= 13'd0;
      pass_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= STS_OK;
      out_aaddr_q  <= 64'd0;
      out_answer_q <= 1'b0;
      out_free_q   <= 13'd0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_REGION_BASE: cfg_base_q  <= cfg_i.data;
          CFG_FRAME_SHIFT: cfg_shift_q <= cfg_i.data[4:0];
          CFG_FRAME_COUNT: cfg_count_q <= cfg_i.data[12:0];
          default: ;
        endcase
      end

      if (done_q && (!out_valid_q || rsp_o.ready)) begin
        done_q       <= 1'b0;
        out_valid_q  <= 1'b1;
        out_status_q <= sts_q;
        out_aaddr_q  <= (sts_q == STS_OK && op_q == OP_ALLOC) ? aaddr_q : 64'd0;
        out_answer_q <= (sts_q == STS_OK && op_q == OP_CHECK) ? (want_q ? hit_q : !hit_q)
                                                              : 1'b0;
        out_free_q   <= free_q;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid && !done_q) begin
            op_q    <= req_i.opcode;
            size_q  <= req_i.size_bytes;
            addr_q  <= req_i.address;
            eaddr_q <= req_i.end_address;
            want_q  <= req_i.want_used;
            hit_q   <= 1'b0;
            if (req_i.opcode > OP_INIT) begin
              sts_q  <= STS_INVALID;
              done_q <= 1'b1;
            end else if (req_i.opcode == OP_INIT) begin
              if (cfg_count_q == 13'd0 || cfg_count_q > 13'(MAX_FRAMES)) begin
                sts_q  <= STS_INVALID;
                done_q <= 1'b1;
              end else begin
                sts_q   <= STS_OK;
                base_q  <= cfg_base_q;
                shift_q <= cfg_shift_q;
                count_q <= cfg_count_q;
                words_q <= cnt_words;
                w_q     <= 6'd0;
                state_q <= S_INIT;
              end
            end else if (!init_q) begin
              sts_q  <= STS_UNINIT;
              done_q <= 1'b1;
            end else begin
              sts_q   <= STS_OK;
              state_q <= S_PRE1;
            end
          end
        end
        S_INIT: begin
          w_q <= w_q + 6'd1;
          if (w_q == 6'(MAP_WORDS - 1)) begin
            free_q  <= count_q;
            sw_q    <= 6'd0;
            init_q  <= 1'b1;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_PRE1: begin
          need_q  <= need_c;
          s_q     <= addr_q & ~fm;
          eraw_q  <= (op_q == OP_RESERVE) ? addr_q + size_q : eaddr_q;
          off_q   <= addr_q - base_q;
          span_q  <= span_c;
          state_q <= S_PRE2;
        end
        S_PRE2: begin
          e_q     <= ((eraw_q & fm) != 64'd0) ? (eraw_q | fm) + 64'd1 : eraw_q;
          sb_q    <= s_q - base_q;
          rem_q   <= span_q - off_q;
          state_q <= S_PRE3;
        end
        S_PRE3: begin
          eb_q    <= eb_c;
          state_q <= S_PRE4;
          if (bad_c) begin
            sts_q <= STS_INVALID;
          end else if (op_q == OP_ALLOC && need_q > {51'd0, free_q}) begin
            sts_q <= STS_NO_MEM;
          end else if (op_q == OP_FREE && (rem_q >> shift_q) < need_q) begin
            sts_q <= STS_BAD_STATE;
          end
        end
        S_PRE4: begin
          rfirst_q <= first_c;
          cur_q    <= first_c;
          if (sts_q != STS_OK) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            case (op_q)
              OP_ALLOC: begin
                n_q     <= need_q[12:0];
                f_q     <= {1'b0, sw_q, 6'd0};
                hi_q    <= {words_q, 6'd0};
                run_q   <= 13'd0;
                pass_q  <= 1'b0;
                state_q <= S_SRD;
              end
              OP_FREE: begin
                n_q     <= need_q[12:0];
                rend_q  <= first_c + need_q[12:0];
                rmode_q <= RM_TEST_USED;
                state_q <= S_RRD;
              end
              OP_RESERVE: begin
                n_q    <= nrc;
                rend_q <= last_c;
                rmode_q <= RM_SET;
                if (nrc > free_q) begin
                  sts_q   <= STS_NO_MEM;
                  done_q  <= 1'b1;
                  state_q <= S_IDLE;
                end else if (nrc == 13'd0) begin
                  done_q  <= 1'b1;
                  state_q <= S_IDLE;
                end else begin
                  state_q <= S_RRD;
                end
              end
              default: begin
                rend_q  <= last_c;
                rmode_q <= RM_TEST_ANY;
                if (nrc == 13'd0) begin
                  done_q  <= 1'b1;
                  state_q <= S_IDLE;
                end else begin
                  state_q <= S_RRD;
                end
              end
            endcase
          end
        end
        S_SRD: begin
          state_q <= S_SSCAN;
        end
        S_SSCAN: begin
          if (!fbit && (run_q + 13'd1 == n_q)) begin
            rstart_q <= rs_c;
            rfirst_q <= rs_c;
            cur_q    <= rs_c;
            rend_q   <= rs_c + n_q;
            sw_q     <= f_q[11:6];
            rmode_q  <= RM_SET;
            pass_q   <= 1'b1;
            hi_q     <= 13'd0;
            run_q    <= 13'd0;
            f_q      <= 13'd0;
            hit_q    <= 1'b1;
            state_q  <= S_RRD;
            aaddr_q  <= base_q + ({51'd0, rs_c} << shift_q);
          end else if (f_nx == hi_q) begin
            if (!pass_q && sw_q != 6'd0) begin
              pass_q  <= 1'b1;
              f_q     <= 13'd0;
              hi_q    <= {1'b0, sw_q, 6'd0};
              run_q   <= 13'd0;
              state_q <= S_SRD;
            end else begin
              sts_q   <= STS_NOT_FOUND;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end else begin
            if (fbit) begin
              run_q <= 13'd0;
            end else begin
              run_q    <= run_q + 13'd1;
              rstart_q <= rs_c;
            end
            f_q <= f_nx;
            if (f_nx[5:0] == 6'd0) begin
              state_q <= S_SRD;
            end
          end
        end
        S_RRD: begin
          state_q <= S_RWR;
        end
        S_RWR: begin
          case (rmode_q)
            RM_TEST_USED: begin
              if ((rdata & rmask) != rmask) begin
                sts_q   <= STS_BAD_STATE;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else if (rlast) begin
                cur_q   <= rfirst_q;
                rmode_q <= RM_CLR;
                state_q <= S_RRD;
              end else begin
                cur_q   <= ncur;
                state_q <= S_RRD;
              end
            end
            RM_TEST_ANY: begin
              if ((rdata & rmask) != '0) begin
                hit_q   <= 1'b1;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else if (rlast) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                cur_q   <= ncur;
                state_q <= S_RRD;
              end
            end
            default: begin
              if (rlast) begin
                free_q  <= (rmode_q == RM_CLR) ? free_q + n_q : free_q - n_q;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                cur_q   <= ncur;
                state_q <= S_RRD;
              end
            end
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/bfa_checker.sv
// Checker: port-level properties of the frame allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bfa_checker import bfa_pkg::*; (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        rsp_valid_i,
  input wire        rsp_ready_i,
  input wire [2:0]  rsp_status_i,
  input wire [63:0] rsp_alloc_address_i,
  input wire        rsp_answer_i,
  input wire [12:0] rsp_free_frames_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response word dropped while stalled");

  a_addr_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != STS_OK |-> rsp_alloc_address_i == 64'd0)
    else $error("address reported on failed request");

  a_answer_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_answer_i |-> rsp_status_i == STS_OK)
    else $error("answer set on failed request");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i <= STS_BAD_STATE)
    else $error("status code out of range");

  a_free_uninit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STS_UNINIT |-> rsp_free_frames_i == 13'd0)
    else $error("free count nonzero before init");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_status_i        (rsp_o.status),
  .rsp_alloc_address_i (rsp_o.alloc_address),
  .rsp_answer_i        (rsp_o.answer),
  .rsp_free_frames_i   (rsp_o.free_frames)
);
`default_nettype wire

FILE: bench/tb.sv
// Testbench for bitmap_frame_allocator: directed table and random phases against a predictor.
`timescale 1ns / 1ps
module tb;
  import bfa_pkg::*;

  localparam longint CYCLE_LIMIT = 30_000_000;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] size;
    logic [63:0] addr;
    logic [63:0] eaddr;
    logic        want;
  } req_t;

  typedef struct {
    status_e     status;
    logic [63:0] addr;
    logic        answer;
    logic [12:0] free;
  } rsp_t;

  typedef struct {
    logic [63:0] addr;
    logic [63:0] size;
  } block_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [63:0] data;
    req_t        req;
    bit          has_exp;
    status_e     status;
    logic [12:0] free;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bfa_req_if req();
  bfa_rsp_if rsp();
  bfa_cfg_if cfg();

  bitmap_frame_allocator DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  always #5 clk = ~clk;

  // register copies and latched map state
  logic [63:0] reg_base;
  logic [4:0]  reg_shift;
  logic [12:0] reg_count;
  logic [63:0] frame_map [MAP_WORDS];
  logic [12:0] free_count;
  int unsigned search_word;
  bit          inited;
  logic [63:0] lat_base;
  int unsigned lat_shift, lat_count, lat_words;

  rsp_t   result_q [$];
  block_t live_blocks [$];
  int     errors;
  longint cycles;
  int     idle_pct, stall_pct;
  rsp_t   got_exp;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic bit frame_used(int unsigned f);
    if (f / WORD_BITS >= MAP_WORDS) return 1'b1;
    return frame_map[f / WORD_BITS][WORD_BITS - 1 - f % WORD_BITS];
  endfunction

  function automatic void frame_mark(int unsigned f, bit used);
    if (f / WORD_BITS < MAP_WORDS) frame_map[f / WORD_BITS][WORD_BITS - 1 - f % WORD_BITS] = used;
  endfunction

  function automatic logic [63:0] frames_for(logic [63:0] sz);
    logic [63:0] m;
    m = (64'd1 << lat_shift) - 1;
    return (sz >> lat_shift) + (((sz & m) != 0) ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [63:0] round_up(logic [63:0] a);
    logic [63:0] m;
    m = (64'd1 << lat_shift) - 1;
    if ((a & m) != 0) a = (a & ~m) + m + 1;
    return a;
  endfunction

  function automatic bit find_run(int unsigned lo, int unsigned hi, logic [63:0] need,
                                  output int unsigned start);
    int unsigned rs;
    logic [63:0] run;
    rs = 0;
    run = 0;
    start = 0;
    for (int unsigned f = lo; f < hi; f++) begin
      if (frame_used(f)) begin
        run = 0;
      end else begin
        if (run == 0) rs = f;
        run++;
        if (run == need) begin
          start = rs;
          search_word = f / WORD_BITS;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t allocate_frames(req_t r);
    rsp_t o;
    logic [63:0] fmask, span, need, s, e;
    int unsigned first, last, n, sw;
    bit hit, bad;
    o = '{STS_OK, 64'd0, 1'b0, 13'd0};
    if (r.op > OP_INIT) begin
      o.status = STS_INVALID;
    end else if (r.op == OP_INIT) begin
      if (reg_count == 0 || reg_count > MAX_FRAMES) begin
        o.status = STS_INVALID;
      end else begin
        lat_base = reg_base;
        lat_shift = reg_shift;
        lat_count = reg_count;
        lat_words = (lat_count + WORD_BITS - 1) / WORD_BITS;
        foreach (frame_map[i]) frame_map[i] = '0;
        for (int unsigned f = lat_count; f < lat_words * WORD_BITS; f++) frame_mark(f, 1'b1);
        free_count = reg_count;
        search_word = 0;
        inited = 1'b1;
        live_blocks.delete();
      end
    end else if (!inited) begin
      o.status = STS_UNINIT;
    end else begin
      fmask = (64'd1 << lat_shift) - 1;
      span = 64'(lat_count) << lat_shift;
      if (r.op == OP_ALLOC) begin
        need = frames_for(r.size);
        sw = search_word;
        if (need == 0) o.status = STS_INVALID;
        else if (need > free_count) o.status = STS_NO_MEM;
        else begin
          hit = find_run(sw * WORD_BITS, lat_words * WORD_BITS, need, first);
          if (!hit) hit = find_run(0, sw * WORD_BITS, need, first);
          if (hit) begin
            for (int unsigned k = 0; k < need; k++) frame_mark(first + k, 1'b1);
            o.addr = lat_base + (64'(first) << lat_shift);
            free_count = free_count - need[12:0];
            live_blocks.push_back('{o.addr, r.size});
          end else begin
            o.status = STS_NOT_FOUND;
          end
        end
      end else if (r.op == OP_FREE) begin
        need = frames_for(r.size);
        if (r.size == 0 || need > lat_count || (r.addr & fmask) != 0 ||
            r.addr < lat_base || r.addr - lat_base >= span) begin
          o.status = STS_INVALID;
        end else if (((span - (r.addr - lat_base)) >> lat_shift) < need) begin
          o.status = STS_BAD_STATE;
        end else begin
          first = 32'((r.addr - lat_base) >> lat_shift);
          for (int unsigned k = 0; k < need; k++)
            if (!frame_used(first + k)) begin
              o.status = STS_BAD_STATE;
              break;
            end
          if (o.status == STS_OK) begin
            for (int unsigned k = 0; k < need; k++) frame_mark(first + k, 1'b0);
            free_count = free_count + need[12:0];
          end
        end
      end else begin
        s = r.addr & ~fmask;
        e = (r.op == OP_RESERVE) ? round_up(r.addr + r.size) : round_up(r.eaddr);
        if (r.op == OP_RESERVE) bad = (r.size == 0) || e < s;
        else bad = (s >= e);
        if (!bad) bad = s < lat_base || e < lat_base || e - lat_base > span;
        if (bad) begin
          o.status = STS_INVALID;
        end else begin
          first = 32'((s - lat_base) >> lat_shift);
          last = 32'((e - lat_base) >> lat_shift);
          n = (last > first) ? last - first : 0;
          if (r.op == OP_RESERVE) begin
            if (n > free_count) o.status = STS_NO_MEM;
            else begin
              free_count = free_count - n[12:0];
              for (int unsigned k = 0; k < n; k++) frame_mark(first + k, 1'b1);
            end
          end else begin
            hit = 1'b0;
            for (int unsigned k = 0; k < n; k++)
              if (frame_used(first + k)) begin
                hit = 1'b1;
                break;
              end
            o.answer = r.want ? hit : !hit;
          end
        end
      end
    end
    o.free = free_count;
    return o;
  endfunction

  task automatic send_req(req_t r, bit has_exp = 0, rsp_t typed = '{STS_OK, 0, 0, 0});
    rsp_t p;
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= r.op;
    req.size_bytes <= r.size;
    req.address <= r.addr;
    req.end_address <= r.eaddr;
    req.want_used <= r.want;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    p = allocate_frames(r);
    result_q.push_back(has_exp ? typed : p);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      CFG_REGION_BASE: reg_base = val;
      CFG_FRAME_SHIFT: reg_shift = val[4:0];
      CFG_FRAME_COUNT: reg_count = val[12:0];
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_item();
    req_t r;
    int pick, idx;
    int unsigned f, n;
    logic [63:0] fmask;
    fmask = (64'd1 << lat_shift) - 1;
    r = '{OP_ALLOC, 64'd0, 64'd0, 64'd0, 1'b0};
    r.want = 1'($urandom_range(1));
    pick = $urandom_range(99);
    f = $urandom_range(lat_count - 1);
    n = ($urandom_range(9) == 0) ? $urandom_range(1, lat_count) : $urandom_range(1, 6);
    if (pick < 35) begin
      r.op = OP_ALLOC;
      r.size = (64'(n) << lat_shift) - (64'($urandom) & fmask);
    end else if (pick < 55) begin
      r.op = OP_FREE;
      if (live_blocks.size() != 0 && $urandom_range(4) != 0) begin
        idx = $urandom_range(live_blocks.size() - 1);
        r.addr = live_blocks[idx].addr;
        r.size = live_blocks[idx].size;
        live_blocks.delete(idx);
      end else begin
        r.addr = lat_base + (64'(f) << lat_shift);
        r.size = 64'(n) << lat_shift;
      end
    end else if (pick < 66) begin
      r.op = OP_RESERVE;
      r.addr = lat_base + (64'(f) << lat_shift) + (64'($urandom) & fmask);
      r.size = 64'($urandom_range(1, 4)) << lat_shift;
    end else if (pick < 82) begin
      r.op = OP_CHECK;
      r.addr = lat_base + (64'(f) << lat_shift) + (64'($urandom) & fmask);
      r.eaddr = lat_base + (64'(f + n) << lat_shift) - (64'($urandom) & fmask);
    end else if (pick < 84) begin
      r.op = OP_INIT;
    end else begin
      r.op = 3'($urandom_range(7));
      r.size = ($urandom_range(1)) ? rand64() : 64'($urandom_range(3)) << lat_shift;
      r.addr = ($urandom_range(1)) ? rand64() : lat_base + (64'($urandom) & fmask);
      r.eaddr = rand64();
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      if (result_q.size() == 0) begin
        report("unexpected word", {61'd0, rsp.status}, 64'd0);
      end else begin
        got_exp = result_q.pop_front();
        if (rsp.status !== got_exp.status)
          report("status", 64'(rsp.status), 64'(got_exp.status));
        if (rsp.alloc_address !== got_exp.addr)
          report("alloc_address", rsp.alloc_address, got_exp.addr);
        if (rsp.answer !== got_exp.answer)
          report("answer", 64'(rsp.answer), 64'(got_exp.answer));
        if (rsp.free_frames !== got_exp.free)
          report("free_frames", 64'(rsp.free_frames), 64'(got_exp.free));
      end
    end
  end

  row_t        rows [$];
  int          ph_count [8] = '{200, 64, 1, 4096, 300, 130, 4000, 97};
  int          ph_shift [8] = '{12, 0, 5, 12, 31, 3, 1, 20};
  int          ph_idle  [8] = '{0, 53, 0, 36, 36, 53, 0, 36};
  int          ph_stall [8] = '{0, 0, 53, 36, 36, 0, 53, 36};
  int          ph_items [8] = '{300, 300, 120, 80, 300, 300, 80, 340};
  logic [63:0] ph_base;

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    reg_base = 64'd0;
    reg_shift = 5'd12;
    reg_count = 13'd4096;
    foreach (frame_map[i]) frame_map[i] = '0;
    free_count = 0;
    search_word = 0;
    inited = 1'b0;
    lat_base = 0;
    lat_shift = 0;
    lat_count = 0;
    lat_words = 0;
    req.valid = 1'b0;
    req.opcode = OP_ALLOC;
    req.size_bytes = '0;
    req.address = '0;
    req.end_address = '0;
    req.want_used = 1'b0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_REGION_BASE;
    cfg.data = '0;

    rows.push_back('{0, 0, 0, '{OP_ALLOC, 4096, 0, 0, 0}, 1, STS_UNINIT, 0});
    rows.push_back('{0, 0, 0, '{OP_CHECK, 0, 0, 4096, 1}, 1, STS_UNINIT, 0});
    rows.push_back('{0, 0, 0, '{3'd7, '1, '1, '1, 1}, 1, STS_INVALID, 0});
    rows.push_back('{1, CFG_FRAME_COUNT, 64'd0, '{OP_ALLOC, 0, 0, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_INIT, 0, 0, 0, 0}, 1, STS_INVALID, 0});
    rows.push_back('{1, CFG_FRAME_COUNT, 64'd8191, '{OP_ALLOC, 0, 0, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_INIT, 0, 0, 0, 0}, 1, STS_INVALID, 0});
    rows.push_back('{1, CFG_FRAME_COUNT, 64'd64, '{OP_ALLOC, 0, 0, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{1, CFG_REGION_BASE, 64'h1000_0000, '{OP_ALLOC, 0, 0, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{1, 2'd3, '1, '{OP_ALLOC, 0, 0, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_INIT, 0, 0, 0, 0}, 1, STS_OK, 64});
    rows.push_back('{0, 0, 0, '{OP_ALLOC, 0, 0, 0, 0}, 1, STS_INVALID, 64});
    rows.push_back('{0, 0, 0, '{OP_ALLOC, 1, 0, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_ALLOC, 64'h4_0000, 0, 0, 0}, 1, STS_NO_MEM, 63});
    rows.push_back('{0, 0, 0, '{OP_ALLOC, '1, 0, 0, 0}, 1, STS_NO_MEM, 63});
    rows.push_back('{0, 0, 0, '{OP_FREE, 4096, 64'h1000_0001, 0, 0}, 1, STS_INVALID, 63});
    rows.push_back('{0, 0, 0, '{OP_FREE, 4096, 64'h1000_0000, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_FREE, 4096, 64'h1000_0000, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_RESERVE, 8192, 64'h1000_a000, 0, 0}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_RESERVE, 0, 64'h1000_0000, 0, 0}, 1, STS_INVALID, 62});
    rows.push_back('{0, 0, 0, '{OP_CHECK, 0, 64'h1000_9000, 64'h1000_c000, 1}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_CHECK, 0, 64'h1000_9000, 64'h1000_c000, 0}, 0, STS_OK, 0});
    rows.push_back('{0, 0, 0, '{OP_CHECK, 0, 64'h1000_2000, 64'h1000_1000, 0}, 1, STS_INVALID, 62});
    rows.push_back('{0, 0, 0, '{3'd5, 0, 0, 0, 0}, 1, STS_INVALID, 62});
    rows.push_back('{0, 0, 0, '{3'd6, 0, 0, 0, 0}, 1, STS_INVALID, 62});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_req(rows[i].req, rows[i].has_exp, '{rows[i].status, 64'd0, 1'b0, rows[i].free});
      end
    end

    for (int p = 0; p < 8; p++) begin
      drain();
      idle_pct = ph_idle[p];
      stall_pct = ph_stall[p];
      ph_base = (p == 4) ? 64'hFFFF_FF00_0000_0000 : (p < 2 || p == 3) ? 64'h8000_0000 * p :
                rand64();
      ph_base = ph_base & ~((64'd1 << ph_shift[p]) - 1);
      write_reg(CFG_REGION_BASE, ph_base);
      write_reg(CFG_FRAME_SHIFT, 64'(ph_shift[p]));
      write_reg(CFG_FRAME_COUNT, 64'(ph_count[p]));
      send_req('{OP_INIT, 0, 0, 0, 0});
      for (int k = 0; k < ph_items[p]; k++) begin
        if (p == 1 && k == ph_items[p] / 2) drain();
        send_req(make_item());
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bfa_pkg.sv
design/bfa_if.sv
design/bfa_map_ram.sv
design/bitmap_frame_allocator.sv
design/bfa_checker.sv
bench/tb.sv
